// File: design/dbq_pkg.sv
package dbq_pkg;

	localparam int DATA_W = 32;
	localparam int DBQ_CAPACITY = 64;

	// Value returned by a pop from an empty queue (-1).
	localparam logic [DATA_W-1:0] EMPTY_POP_DATA = '1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	typedef enum logic [3:0] {
		REQ_PUSH_BACK  = 4'd0,
		REQ_PUSH_FRONT = 4'd1,
		REQ_POP_BACK   = 4'd2,
		REQ_POP_FRONT  = 4'd3,
		REQ_READ       = 4'd4,
		REQ_WRITE      = 4'd5,
		REQ_INSERT     = 4'd6,
		REQ_ERASE      = 4'd7,
		REQ_CLEAR      = 4'd8
	} req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CAP_D,
		S_SH_RD,
		S_SH_WR,
		S_PUT,
		S_ER_END,
		S_RD_F,
		S_CAP_F,
		S_RD_B,
		S_CAP_B,
		S_DONE
	} seq_state_t;

	// Result of one request, apart from the element count.
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [1:0]        status;
		logic [DATA_W-1:0] front;
		logic [DATA_W-1:0] back;
	} res_t;

endpackage

// File: design/bounded_double_ended_queue_unit.sv
// Bounded double-ended queue of signed 32-bit values held in a ring of CAPACITY entries in
// one synchronous RAM with a single write port and a single registered read port.
// Each input transaction carries one request (push or pop at either end, read, write, insert
// before an index, erase at an index, or clear) and yields exactly one output transaction
// with the data involved, a status, the element count and the front and back values after
// the request. Requests are handled one at a time and every RAM read gets its own state:
// push, write, clear and any refused request go straight to the result; a pop that leaves
// entries reads the new front or back from the RAM; read captures the RAM data; insert
// shifts the entries from the index on up by one and then puts the value; erase captures
// the erased entry, shifts the entries behind it down and, unless the queue is then empty,
// rereads the front and back. Insert and erase move one entry per read-then-write pair
// through the RAM, so they grow with the number of entries behind the index. The result
// sits in an output register, so a new request is taken as soon as the sequencer is back
// in idle even if the previous result is still waiting for out_ready. The front and back
// values are kept in registers and refreshed from the RAM after pops and erases. Only
// entries within the count are ever read, so the RAM needs no clearing after reset.
module bounded_double_ended_queue_unit import dbq_pkg::*; #(
	parameter int CAPACITY = DBQ_CAPACITY
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [3:0]                          req_type,
	input  logic signed [DATA_W-1:0]            value,
	input  logic [$clog2(CAPACITY+1)-1:0]       position,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [DATA_W-1:0]            data,
	output logic [1:0]                          status,
	output logic [$clog2(CAPACITY+1)-1:0]       count,
	output logic signed [DATA_W-1:0]            front_value,
	output logic signed [DATA_W-1:0]            back_value
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic res_valid;
	logic res_take;
	res_t res;
	logic [CNT_W-1:0] res_count;

	logic out_valid_q;
	res_t out_q;
	logic [CNT_W-1:0] count_q;

	// The sequencer owns the RAM and all queue state; it holds its result until the
	// output register is free.
	dbq_seq #(.CAPACITY(CAPACITY)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (req_type),
		.in_value  (value),
		.in_pos    (position),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.res_count (res_count)
	);

	// The output register can take a new result when it is empty or being drained.
	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
			count_q <= res_count;
		end
	end

	assign out_valid = out_valid_q;
	assign data = out_q.data;
	assign status = out_q.status;
	assign count = count_q;
	assign front_value = out_q.front;
	assign back_value = out_q.back;

endmodule

// File: design/dbq_ram.sv
module dbq_ram import dbq_pkg::*; #(
	parameter int DEPTH = DBQ_CAPACITY
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/dbq_seq.sv
module dbq_seq import dbq_pkg::*; #(
	parameter int CAPACITY = DBQ_CAPACITY
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [3:0]                         in_req,
	input  logic [DATA_W-1:0]                  in_value,
	input  logic [$clog2(CAPACITY+1)-1:0]      in_pos,
	output logic                               res_valid,
	input  logic                               res_take,
	output res_t                               res,
	output logic [$clog2(CAPACITY+1)-1:0]      res_count
);

	localparam int PTR_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_M1 = CNT_W'(CAPACITY - 1);
	localparam logic [CNT_W:0] CAP_W = (CNT_W+1)'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	// Ring slot of a logical index; the sum stays below twice the capacity.
	function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] fp,
		input logic [CNT_W-1:0] idx);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(fp) + {1'b0, idx};
		if (sum >= CAP_W) begin
			sum = sum - CAP_W;
		end
		return sum[PTR_W-1:0];
	endfunction

	seq_state_t state_q, state_d;
	req_t req_q, req_d, in_req_t;
	logic [PTR_W-1:0] fp_q, fp_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] i_q, i_d;
	logic ref_b_q, ref_b_d;
	logic [DATA_W-1:0] val_q, val_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [DATA_W-1:0] front_q, front_d, back_q, back_d, data_q, data_d;
	logic [1:0] status_q, status_d;

	logic full, empty, pos_lt, pos_le;
	logic [CNT_W-1:0] rd_idx, wr_idx;
	logic [PTR_W-1:0] rd_slot, wr_slot;
	logic ram_we, ram_re;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;
	logic [CNT_W:0] i_p1, i_p2;

	assign in_req_t = req_t'(in_req);
	assign full = (cnt_q == CAP_C);
	assign empty = (cnt_q == '0);
	assign pos_lt = (in_pos < cnt_q);
	assign pos_le = (in_pos <= cnt_q);
	assign i_p1 = {1'b0, i_q} + (CNT_W+1)'(1);
	assign i_p2 = {1'b0, i_q} + (CNT_W+1)'(2);
	assign rd_slot = slot_of(fp_q, rd_idx);
	assign wr_slot = slot_of(fp_q, wr_idx);

	dbq_ram #(.DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_slot),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_slot),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_req_t)
						REQ_POP_BACK: state_d = (cnt_q > ONE_C) ? S_RD_B : S_DONE;
						REQ_POP_FRONT: state_d = (cnt_q > ONE_C) ? S_RD_F : S_DONE;
						REQ_READ, REQ_ERASE: state_d = pos_lt ? S_CAP_D : S_DONE;
						REQ_INSERT: begin
							if (!full && pos_le) begin
								state_d = (in_pos == cnt_q) ? S_PUT : S_SH_RD;
							end else begin
								state_d = S_DONE;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_CAP_D: begin
				if (req_q == REQ_ERASE) begin
					state_d = (i_p1 < {1'b0, cnt_q}) ? S_SH_RD : S_ER_END;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SH_RD: state_d = S_SH_WR;
			S_SH_WR: begin
				if (req_q == REQ_INSERT) begin
					state_d = ((i_q - ONE_C) == pos_q) ? S_PUT : S_SH_RD;
				end else begin
					state_d = (i_p2 < {1'b0, cnt_q}) ? S_SH_RD : S_ER_END;
				end
			end
			S_PUT: state_d = S_DONE;
			S_ER_END: state_d = (cnt_q == ONE_C) ? S_DONE : S_RD_F;
			S_RD_F: state_d = S_CAP_F;
			S_CAP_F: state_d = ref_b_q ? S_RD_B : S_DONE;
			S_RD_B: state_d = S_CAP_B;
			S_CAP_B: state_d = S_DONE;
			S_DONE: state_d = res_take ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_wdata = in_value;
		rd_idx = '0;
		wr_idx = '0;
		req_d = req_q;
		fp_d = fp_q;
		cnt_d = cnt_q;
		i_d = i_q;
		ref_b_d = ref_b_q;
		val_d = val_q;
		pos_d = pos_q;
		front_d = front_q;
		back_d = back_q;
		data_d = data_q;
		status_d = status_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					req_d = in_req_t;
					val_d = in_value;
					pos_d = in_pos;
					i_d = in_pos;
					ref_b_d = 1'b0;
					data_d = '0;
					status_d = ST_OK;
					case (in_req_t)
						REQ_PUSH_BACK: begin
							if (full) begin
								status_d = ST_ERROR;
							end else begin
								ram_we = 1'b1;
								wr_idx = cnt_q;
								cnt_d = cnt_q + ONE_C;
								back_d = in_value;
								if (empty) begin
									front_d = in_value;
								end
								data_d = in_value;
							end
						end
						REQ_PUSH_FRONT: begin
							if (full) begin
								status_d = ST_ERROR;
							end else begin
								ram_we = 1'b1;
								wr_idx = CAP_M1;
								fp_d = wr_slot;
								cnt_d = cnt_q + ONE_C;
								front_d = in_value;
								if (empty) begin
									back_d = in_value;
								end
								data_d = in_value;
							end
						end
						REQ_POP_BACK: begin
							if (empty) begin
								data_d = EMPTY_POP_DATA;
								status_d = ST_EMPTY;
							end else begin
								data_d = back_q;
								cnt_d = cnt_q - ONE_C;
							end
						end
						REQ_POP_FRONT: begin
							if (empty) begin
								data_d = EMPTY_POP_DATA;
								status_d = ST_EMPTY;
							end else begin
								data_d = front_q;
								rd_idx = ONE_C;
								fp_d = rd_slot;
								cnt_d = cnt_q - ONE_C;
							end
						end
						REQ_READ: begin
							if (pos_lt) begin
								ram_re = 1'b1;
								rd_idx = in_pos;
							end else begin
								status_d = ST_ERROR;
							end
						end
						REQ_WRITE: begin
							if (pos_lt) begin
								ram_we = 1'b1;
								wr_idx = in_pos;
								data_d = in_value;
								if (in_pos == '0) begin
									front_d = in_value;
								end
								if (in_pos == (cnt_q - ONE_C)) begin
									back_d = in_value;
								end
							end else begin
								status_d = ST_ERROR;
							end
						end
						REQ_INSERT: begin
							if (!full && pos_le) begin
								i_d = cnt_q;
							end else begin
								status_d = ST_ERROR;
							end
						end
						REQ_ERASE: begin
							if (pos_lt) begin
								ram_re = 1'b1;
								rd_idx = in_pos;
								ref_b_d = 1'b1;
							end else begin
								status_d = ST_ERROR;
							end
						end
						REQ_CLEAR: begin
							cnt_d = '0;
							fp_d = '0;
						end
						default: status_d = ST_ERROR;
					endcase
				end
			end
			S_CAP_D: data_d = ram_rdata;
			S_SH_RD: begin
				ram_re = 1'b1;
				rd_idx = (req_q == REQ_INSERT) ? (i_q - ONE_C) : i_p1[CNT_W-1:0];
			end
			S_SH_WR: begin
				ram_we = 1'b1;
				wr_idx = i_q;
				ram_wdata = ram_rdata;
				i_d = (req_q == REQ_INSERT) ? (i_q - ONE_C) : i_p1[CNT_W-1:0];
			end
			S_PUT: begin
				ram_we = 1'b1;
				wr_idx = pos_q;
				ram_wdata = val_q;
				cnt_d = cnt_q + ONE_C;
				data_d = val_q;
				if (pos_q == '0) begin
					front_d = val_q;
				end
				if (pos_q == cnt_q) begin
					back_d = val_q;
				end
			end
			S_ER_END: cnt_d = cnt_q - ONE_C;
			S_RD_F: begin
				ram_re = 1'b1;
				rd_idx = '0;
			end
			S_CAP_F: front_d = ram_rdata;
			S_RD_B: begin
				ram_re = 1'b1;
				rd_idx = cnt_q - ONE_C;
			end
			S_CAP_B: back_d = ram_rdata;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= REQ_CLEAR;
			fp_q <= '0;
			cnt_q <= '0;
			i_q <= '0;
			ref_b_q <= 1'b0;
		end else begin
			state_q <= state_d;
			req_q <= req_d;
			fp_q <= fp_d;
			cnt_q <= cnt_d;
			i_q <= i_d;
			ref_b_q <= ref_b_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
		pos_q <= pos_d;
		front_q <= front_d;
		back_q <= back_d;
		data_q <= data_d;
		status_q <= status_d;
	end

	assign in_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res.data = data_q;
	assign res.status = status_q;
	assign res.front = empty ? '0 : front_q;
	assign res.back = empty ? '0 : back_q;
	assign res_count = cnt_q;

endmodule
